// ===== sv/gclk_pkg.sv =====
package gclk_pkg;

    localparam int WAYS      = 4;
    localparam int COUNT_MAX = 15;
    localparam int BLOCK_W   = 16;
    localparam int HITS_W    = 16;
    localparam int CNT_W     = $clog2(COUNT_MAX + 1);

    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] block;
        logic [CNT_W-1:0]   count;
    } entry_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic               lookup;   // transfer missed, fill the first empty cell
        logic               hit;      // transfer hit, bump the matching count
        logic               shift;    // rotate the ring one place toward the hand
        logic [BLOCK_W-1:0] key;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

// ===== sv/gclk_cell.sv =====
module gclk_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  gclk_pkg::cell_ctrl_t ctrl,
    input  logic               empty_in,
    input  gclk_pkg::entry_t   nbr,
    output logic               empty_out,
    output gclk_pkg::entry_t   state,
    output logic               match
);
    import gclk_pkg::*;

    localparam logic [CNT_W-1:0] CntMax = CNT_W'(COUNT_MAX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   fill;

    assign match     = entry_reg.valid && (entry_reg.block == ctrl.key);
    // an empty cell fills only if no cell closer to the head is empty
    assign fill      = ctrl.lookup && !entry_reg.valid && !empty_in;
    assign empty_out = empty_in || !entry_reg.valid;
    assign state     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = nbr;
        end
        else if (fill)
        begin
            entry_next.valid = 1'b1;
            entry_next.block = ctrl.key;
            entry_next.count = '0;
        end
        else if (match && ctrl.hit && (entry_reg.count < CntMax))
        begin
            entry_next.count = entry_reg.count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== sv/counting_clock_cache_replacement.sv =====
// hit or fill of an empty entry: the result is registered in the cycle after the input transfer
// miss on a full cache: the ring rotates and each count at the hand is decremented
// until a zero count sits at the hand; that entry is then replaced by the new block
// one access in flight at a time; a new transfer is taken once the result register is free
// reset clears all valid bits, counts, the scan state and the hit total
module counting_clock_cache_replacement (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [gclk_pkg::BLOCK_W-1:0] block,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit
);
    import gclk_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [BLOCK_W-1:0]  key_reg;
    logic [HITS_W-1:0]   hits_reg;
    logic                out_valid_reg;
    logic                hit_reg;

    entry_t              ent   [WAYS];
    entry_t              nbr   [WAYS];
    logic [WAYS:0]       empty_chain;
    logic [WAYS-1:0]     match_vec;
    entry_t              aged;
    cell_ctrl_t          ctrl;

    logic                accept;
    logic                any_hit;
    logic                full;
    logic                victim;
    logic                scan_shift;
    logic                load_out;
    logic                out_hit_next;

    assign accept  = in_valid && !in_stall;
    assign any_hit = |match_vec;
    assign full    = !empty_chain[WAYS];
    // hand sits at cell 0; its count is zero when the scan ends
    assign victim  = (ent[0].count == '0);

    assign empty_chain[0] = 1'b0;

    // entry that cell 0 hands to the tail of the ring
    always_comb
    begin
        aged = ent[0];
        if (victim)
        begin
            aged.valid = 1'b1;
            aged.block = key_reg;
            aged.count = '0;
        end
        else
        begin
            aged.count = ent[0].count - 1'b1;
        end
    end

    always_comb
    begin
        ctrl.key    = (state_reg == S_SCAN) ? key_reg : block;
        ctrl.lookup = accept && !any_hit;
        ctrl.hit    = accept && any_hit;
        ctrl.shift  = scan_shift;
    end

    genvar gi;
    generate
        for (gi = 0; gi < WAYS; gi++)
        begin : g_cell
            if (gi == WAYS - 1)
            begin : g_tail
                assign nbr[gi] = aged;
            end
            else
            begin : g_mid
                assign nbr[gi] = ent[gi+1];
            end
            gclk_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .empty_in  (empty_chain[gi]),
                .nbr       (nbr[gi]),
                .empty_out (empty_chain[gi+1]),
                .state     (ent[gi]),
                .match     (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !any_hit && full)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (victim)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        scan_shift   = 1'b0;
        load_out     = 1'b0;
        out_hit_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall     = out_valid_reg && out_stall;
                load_out     = accept && (any_hit || !full);
                out_hit_next = any_hit;
            end
            S_SCAN:
            begin
                scan_shift = 1'b1;
                load_out   = victim;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && any_hit)
            begin
                hits_reg <= hits_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= block;
        end
        if (load_out)
        begin
            hit_reg <= out_hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("block resident in more than one entry");

    a_scan_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> in_stall)
        else $error("input taken during hand scan");

    a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && victim) |=> (out_valid_reg && !hit_reg))
        else $error("replacement did not post a miss result");

    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> full)
        else $error("hand scan with an empty entry");

    a_hits_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && any_hit) |=> (hits_reg == $past(hits_reg) + 1'b1))
        else $error("hit total not advanced");

endmodule
